// File: hdl/vupf_pkg.sv
// vupf_pkg: shared types, constants and float helpers for the vector unpack core
// no dependencies; imported by every module under hdl/
package vupf_pkg;

    localparam int LANE_COUNT  = 4;
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    localparam logic [1:0] CFG_FORMAT = 2'd0;
    localparam logic [1:0] CFG_MASK   = 2'd1;
    localparam logic [1:0] CFG_SCALE  = 2'd2;

    // source format codes
    localparam logic [2:0] FMT_F32V4 = 3'd0;
    localparam logic [2:0] FMT_S16V4 = 3'd1;
    localparam logic [2:0] FMT_U8V4  = 3'd2;
    localparam logic [2:0] FMT_F32V2 = 3'd3;

    // reset values
    localparam logic [2:0]  FORMAT_RESET     = FMT_F32V4;
    localparam logic [3:0]  MASK_RESET       = 4'hF;
    localparam logic [31:0] SCALE_RESET      = 32'h3F80_0000;
    localparam logic [31:0] FACTOR_S16_RESET = 32'h3800_0000;
    localparam logic [31:0] FACTOR_U8_RESET  = 32'h3B80_8081;

    // float constants
    localparam logic [31:0] FLT_DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] FLT_QUIET_BIT   = 32'h0040_0000;

    // divisors as normalized mantissa and unbiased exponent
    localparam logic [23:0] DIV32768_MANT = 24'h80_0000;
    localparam logic [10:0] DIV32768_EXP  = 11'd15;
    localparam logic [23:0] DIV255_MANT   = 24'hFF_0000;
    localparam logic [10:0] DIV255_EXP    = 11'd7;

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_S16,
        MODE_U8
    } mode_t;

    typedef struct packed {
        logic        neg;
        logic [15:0] mag;
        logic [31:0] raw;
    } lane_t;

    typedef struct packed {
        lane_t [LANE_COUNT-1:0] lane;
        mode_t                  mode;
        logic [LANE_COUNT-1:0]  en;
        logic                   bad;
        logic                   last;
    } item_t;

    typedef struct packed {
        logic [31:0] s16;
        logic [31:0] u8;
    } factors_t;

    // round to nearest even and pack; q holds 24 mantissa bits plus guard
    function automatic logic [31:0] round_pack(input logic sign,
                                               input logic signed [10:0] exp_b,
                                               input logic [24:0] q,
                                               input logic sticky_in);
        logic [5:0]  sh;
        logic [50:0] wide;
        logic [24:0] qs;
        logic        st;
        logic [7:0]  ef;
        logic        rnd;
        logic [30:0] mag;
        sh   = 6'd0;
        wide = 51'd0;
        ef   = exp_b[7:0];
        qs   = q;
        st   = sticky_in;
        if (exp_b >= 11'sd255) begin
            return {sign, 8'hFF, 23'd0};
        end
        if (exp_b <= 11'sd0) begin
            ef = 8'd0;
            if (exp_b < -11'sd24) begin
                sh = 6'd26;
            end else begin
                sh = 6'(11'sd1 - exp_b);
            end
            wide = {q, 26'd0} >> sh;
            qs   = wide[50:26];
            st   = sticky_in | (|wide[25:0]);
        end
        rnd = qs[0] & (st | qs[1]);
        mag = {ef, qs[23:1]} + 31'(rnd);
        return {sign, mag};
    endfunction

    // leading zero count of a 40-bit product
    function automatic logic [5:0] lzc40(input logic [39:0] v);
        logic [5:0] n;
        n = 6'd40;
        for (int i = 0; i < 40; i++) begin
            if (v[i]) begin
                n = 6'(39 - i);
            end
        end
        return n;
    endfunction

endpackage

// File: hdl/vupf_front.sv
// vupf_front: accepts source vectors and classifies them per format
// depends on vupf_pkg
module vupf_front import vupf_pkg::*; (
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [32*LANE_COUNT-1:0]   s_tdata,   // src_lane0 .. src_lane3, 32 bits each
    input  logic                       s_tlast,   // last_vector
    input  logic [2:0]                 source_format,
    input  logic [LANE_COUNT-1:0]      lane_mask,
    input  logic                       derive_busy,
    input  logic                       queue_full,
    output logic                       push,
    output item_t                      item
);

    // hold off while factors are derived or the queue is full
    assign s_tready = !derive_busy && !queue_full;
    assign push     = s_tvalid && s_tready;

    // per-lane decode into sign and magnitude
    always_comb begin
        item = '0;
        item.last = s_tlast;
        for (int k = 0; k < LANE_COUNT; k++) begin
            item.lane[k].raw = s_tdata[32*k +: 32];
            case (source_format)
                FMT_S16V4: begin
                    item.lane[k].neg = s_tdata[32*k+15];
                    item.lane[k].mag = s_tdata[32*k+15] ? 16'(-s_tdata[32*k +: 16])
                                                        : s_tdata[32*k +: 16];
                end
                FMT_U8V4: begin
                    item.lane[k].neg = 1'b0;
                    item.lane[k].mag = {8'd0, s_tdata[32*k +: 8]};
                end
                default: begin
                    item.lane[k].neg = 1'b0;
                    item.lane[k].mag = 16'd0;
                end
            endcase
        end
        // mode and lane enables
        case (source_format)
            FMT_F32V4: begin
                item.mode = MODE_PASS;
                item.en   = lane_mask;
            end
            FMT_S16V4: begin
                item.mode = MODE_S16;
                item.en   = lane_mask;
            end
            FMT_U8V4: begin
                item.mode = MODE_U8;
                item.en   = lane_mask;
            end
            FMT_F32V2: begin
                item.mode = MODE_PASS;
                item.en   = lane_mask & LANE_COUNT'(3);
            end
            default: begin
                item.mode = MODE_PASS;
                item.en   = '0;
                item.bad  = 1'b1;
            end
        endcase
    end

endmodule

// File: hdl/vupf_queue.sv
// vupf_queue: short register queue between the front and back parts
// depends on vupf_pkg
module vupf_queue import vupf_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t item_in,
    output logic  full,
    input  logic  pop,
    output item_t item_out,
    output logic  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t           store_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign item_out = store_reg[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// File: hdl/vupf_fdiv.sv
// vupf_fdiv: float divide of the scale by 32768 and by 255, residue and inverse multiply
// depends on vupf_pkg
module vupf_fdiv import vupf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] scale,
    output logic        busy,
    output factors_t    factors
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_NORM,
        ST_DIV,
        ST_QUO,
        ST_ROUND
    } state_t;

    state_t             state_reg, state_next;
    logic               sel_reg, sel_next;
    logic [31:0]        scale_reg, scale_next;
    logic [23:0]        mant_reg, mant_next;
    logic signed [10:0] exp_reg, exp_next;
    logic [24:0]        rem_reg, rem_next;
    logic [24:0]        quo_reg, quo_next;
    logic               stk_reg, stk_next;
    logic [31:0]        f16_reg, f16_next;
    logic [31:0]        f8_reg, f8_next;

    logic [23:0]        dmant;
    logic [10:0]        dexp;
    logic [9:0]         mod_sum;
    logic [8:0]         mod_fold;
    logic [7:0]         mod_byte;
    logic [7:0]         mod_val;
    logic [24:0]        inv_t1, inv_t2, quo_inv;
    logic [31:0]        res;
    logic               res_valid;

    assign busy        = (state_reg != ST_IDLE);
    assign factors.s16 = f16_reg;
    assign factors.u8  = f8_reg;
    assign dmant       = sel_reg ? DIV255_MANT : DIV32768_MANT;
    assign dexp        = sel_reg ? DIV255_EXP : DIV32768_EXP;

    // remainder mod 255: byte digits summed, since 256 is 1 mod 255
    assign mod_sum  = 10'(rem_reg[7:0]) + 10'(rem_reg[15:8]) + 10'(rem_reg[23:16])
                    + 10'(rem_reg[24]);
    assign mod_fold = 9'(mod_sum[7:0]) + 9'(mod_sum[9:8]);
    assign mod_byte = mod_fold[7:0] + 8'(mod_fold[8]);
    assign mod_val  = (mod_byte == 8'hFF) ? 8'd0 : mod_byte;

    // exact quotient of a multiple of 255: times the inverse of 255 modulo 2^25
    assign inv_t1  = quo_reg + {quo_reg[16:0], 8'd0};
    assign inv_t2  = inv_t1 + {inv_t1[8:0], 16'd0};
    assign quo_inv = 25'd0 - inv_t2;

    // sequencer: two passes, one per divisor
    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        scale_next = scale_reg;
        mant_next  = mant_reg;
        exp_next   = exp_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        stk_next   = stk_reg;
        f16_next   = f16_reg;
        f8_next    = f8_reg;
        res        = 32'd0;
        res_valid  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    scale_next = scale;
                    sel_next   = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // special operands pass through, a NaN with its quiet bit set
                if (&scale_reg[30:23]) begin
                    res       = scale_reg | ((|scale_reg[22:0]) ? FLT_QUIET_BIT : 32'd0);
                    res_valid = 1'b1;
                end else if (scale_reg[30:0] == 31'd0) begin
                    res       = scale_reg;
                    res_valid = 1'b1;
                end else begin
                    mant_next  = {(|scale_reg[30:23]), scale_reg[22:0]};
                    exp_next   = (|scale_reg[30:23]) ? $signed({3'b0, scale_reg[30:23]})
                                                     : 11'sd1;
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                // one bit a cycle for subnormal scale
                if (!mant_reg[23]) begin
                    mant_next = {mant_reg[22:0], 1'b0};
                    exp_next  = exp_reg - 11'sd1;
                end else begin
                    if (mant_reg < dmant) begin
                        rem_next = {mant_reg, 1'b0};
                        exp_next = exp_reg - 11'sd1;
                    end else begin
                        rem_next = {1'b0, mant_reg};
                    end
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // 32768 is a plain shift; 255 takes the residue and subtracts it
                if (sel_reg) begin
                    quo_next   = {rem_reg[16:0], 8'd0} - 25'(mod_val);
                    stk_next   = (mod_val != 8'd0);
                    state_next = ST_QUO;
                end else begin
                    quo_next   = {rem_reg[23:0], 1'b0};
                    stk_next   = 1'b0;
                    state_next = ST_ROUND;
                end
            end
            ST_QUO: begin
                quo_next   = quo_inv;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                res       = round_pack(scale_reg[31], exp_reg - $signed(dexp), quo_reg,
                                       stk_reg);
                res_valid = 1'b1;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // store a finished factor and move on
        if (res_valid) begin
            if (!sel_reg) begin
                f16_next   = res;
                sel_next   = 1'b1;
                state_next = ST_LOAD;
            end else begin
                f8_next    = res;
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= 1'b0;
            f16_reg   <= FACTOR_S16_RESET;
            f8_reg    <= FACTOR_U8_RESET;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            f16_reg   <= f16_next;
            f8_reg    <= f8_next;
        end
        scale_reg <= scale_next;
        mant_reg  <= mant_next;
        exp_reg   <= exp_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        stk_reg   <= stk_next;
    end

    // quotient reaching the rounder is normalized
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ROUND |-> quo_reg[24])
        else $error("quotient not normalized");

endmodule

// File: hdl/vupf_back.sv
// vupf_back: multiply, normalize and round pipeline with output register
// depends on vupf_pkg
module vupf_back import vupf_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_empty,
    input  item_t                     q_item,
    output logic                      pop,
    input  factors_t                  factors,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [32*LANE_COUNT-1:0]  m_tdata,   // dst_lane0 .. dst_lane3, 32 bits each
    output logic [LANE_COUNT:0]       m_tuser,   // lane_write[3:0], bad_format[4]
    output logic                      m_tlast    // run_end
);

    logic                     adv;
    logic                     b1_valid_reg, b2_valid_reg, out_valid_reg;
    item_t                    b1_item_reg, b2_item_reg;
    logic [31:0]              b1_fac_reg, b2_fac_reg;
    logic [LANE_COUNT-1:0][39:0] b1_prod_reg, b2_prod_reg;
    logic [LANE_COUNT-1:0][5:0]  b2_lz_reg;
    logic [LANE_COUNT-1:0][31:0] out_data_reg;
    logic [LANE_COUNT-1:0]    out_write_reg;
    logic                     out_bad_reg, out_last_reg;

    logic [31:0]              fac_sel;
    logic [23:0]              fac_mant;
    logic [LANE_COUNT-1:0][31:0] lane_val;

    // whole pipeline moves unless the output holds a waiting result
    assign adv = !out_valid_reg || m_tready;
    assign pop = adv && !q_empty;

    assign fac_sel  = (q_item.mode == MODE_U8) ? factors.u8 : factors.s16;
    assign fac_mant = {(|fac_sel[30:23]), fac_sel[22:0]};

    // one lane's float product from the stage two values
    function automatic logic [31:0] lane_result(input mode_t mode, input lane_t ln,
                                                input logic [31:0] f, input logic [39:0] prod,
                                                input logic [5:0] lz);
        logic               fnan, finf, fzero, mzero, s;
        logic [7:0]         efe;
        logic [39:0]        nrm;
        logic signed [10:0] e;
        fnan  = (&f[30:23]) && (|f[22:0]);
        finf  = (&f[30:23]) && !(|f[22:0]);
        fzero = (f[30:0] == 31'd0);
        mzero = (ln.mag == 16'd0);
        s     = ln.neg ^ f[31];
        efe   = (|f[30:23]) ? f[30:23] : 8'd1;
        nrm   = prod << lz;
        e     = 11'sd16 - $signed({5'd0, lz}) + $signed({3'd0, efe});
        if (mode == MODE_PASS) begin
            return ln.raw;
        end else if (fnan) begin
            return f;
        end else if (finf) begin
            return mzero ? FLT_DEFAULT_NAN : {s, 8'hFF, 23'd0};
        end else if (fzero || mzero) begin
            return {s, 31'd0};
        end
        return round_pack(s, e, nrm[39:15], |nrm[14:0]);
    endfunction

    always_comb begin
        for (int k = 0; k < LANE_COUNT; k++) begin
            lane_val[k] = lane_result(b2_item_reg.mode, b2_item_reg.lane[k], b2_fac_reg,
                                      b2_prod_reg[k], b2_lz_reg[k]);
        end
    end

    // stage valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            b1_valid_reg  <= !q_empty;
            b2_valid_reg  <= b1_valid_reg;
            out_valid_reg <= b2_valid_reg;
        end
    end

    // stage payloads: multiply, count leading zeros, round and mask
    always_ff @(posedge aclk) begin
        if (adv) begin
            b1_item_reg <= q_item;
            b1_fac_reg  <= fac_sel;
            for (int k = 0; k < LANE_COUNT; k++) begin
                b1_prod_reg[k] <= q_item.lane[k].mag * fac_mant;
            end
            b2_item_reg <= b1_item_reg;
            b2_fac_reg  <= b1_fac_reg;
            b2_prod_reg <= b1_prod_reg;
            for (int k = 0; k < LANE_COUNT; k++) begin
                b2_lz_reg[k] <= lzc40(b1_prod_reg[k]);
            end
            for (int k = 0; k < LANE_COUNT; k++) begin
                out_data_reg[k] <= b2_item_reg.en[k] ? lane_val[k] : 32'd0;
            end
            out_write_reg <= b2_item_reg.en;
            out_bad_reg   <= b2_item_reg.bad;
            out_last_reg  <= b2_item_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {out_bad_reg, out_write_reg};
    assign m_tlast  = out_last_reg;

    // a bad format never enables a lane
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_bad_reg |-> out_write_reg == '0)
        else $error("bad format result with lanes enabled");

    // a disabled lane 0 carries zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_write_reg[0] |-> out_data_reg[0] == 32'd0)
        else $error("disabled lane 0 not zero");

endmodule

// File: hdl/vector_unpack_to_float4_core.sv
// Vector unpack core: one packed source vector in, four float32 lanes out per cycle.
// Rate is one transfer per clock in both directions unless a factor derivation or
// output back-pressure holds the flow; a result is registered through a queue slot,
// multiply, normalize and round. The integer formats scale by factors that a small
// divider derives after each write of the format or scale register, in two passes, one
// per divisor, normalizing a subnormal scale one bit at a time; while it is busy,
// s_tready and cfg_ready are low. A two-entry queue decouples input from output
// back-pressure.
// depends on vupf_pkg, vupf_front, vupf_queue, vupf_back, vupf_fdiv
module vector_unpack_to_float4_core import vupf_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [31:0]               cfg_data,
    // source vectors
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [32*LANE_COUNT-1:0]  s_tdata,   // src_lane0 .. src_lane3, 32 bits each
    input  logic                      s_tlast,   // last_vector
    // results
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [32*LANE_COUNT-1:0]  m_tdata,   // dst_lane0 .. dst_lane3, 32 bits each
    output logic [LANE_COUNT:0]       m_tuser,   // lane_write[3:0], bad_format[4]
    output logic                      m_tlast    // run_end
);

    logic [2:0]             format_reg, format_next;
    logic [LANE_COUNT-1:0]  mask_reg, mask_next;
    logic [31:0]            scale_reg, scale_next;
    logic                   cfg_write, derive_start, derive_busy;
    factors_t               factors;
    logic                   push, pop, q_full, q_empty;
    item_t                  f_item, q_item;

    assign cfg_ready = !derive_busy;
    assign cfg_write = cfg_valid && cfg_ready;

    // register writes
    always_comb begin
        format_next  = format_reg;
        mask_next    = mask_reg;
        scale_next   = scale_reg;
        derive_start = 1'b0;
        if (cfg_write) begin
            case (cfg_index)
                CFG_FORMAT: begin
                    format_next  = cfg_data[2:0];
                    derive_start = 1'b1;
                end
                CFG_MASK: begin
                    mask_next = cfg_data[LANE_COUNT-1:0];
                end
                CFG_SCALE: begin
                    scale_next   = cfg_data;
                    derive_start = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg <= FORMAT_RESET;
            mask_reg   <= MASK_RESET;
            scale_reg  <= SCALE_RESET;
        end else begin
            format_reg <= format_next;
            mask_reg   <= mask_next;
            scale_reg  <= scale_next;
        end
    end

    vupf_fdiv u_fdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (derive_start),
        .scale   (scale_next),
        .busy    (derive_busy),
        .factors (factors)
    );

    vupf_front u_front (
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .source_format (format_reg),
        .lane_mask     (mask_reg),
        .derive_busy   (derive_busy),
        .queue_full    (q_full),
        .push          (push),
        .item          (f_item)
    );

    vupf_queue #(.DEPTH(QDEPTH)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .item_in  (f_item),
        .full     (q_full),
        .pop      (pop),
        .item_out (q_item),
        .empty    (q_empty)
    );

    vupf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_item   (q_item),
        .pop      (pop),
        .factors  (factors),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // no source or config transfer while factors are being derived
    assert property (@(posedge aclk) disable iff (!aresetn)
        derive_busy |-> !s_tready && !cfg_ready)
        else $error("transfer allowed during factor derivation");

endmodule

// File: test/vector_unpack_to_float4_core_chk.sv
// vector_unpack_to_float4_core_chk: watches the config, source and result channels,
// predicts each result with a bit-exact float32 model and compares; depends on vupf_pkg
module vector_unpack_to_float4_core_chk import vupf_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [31:0]              cfg_data,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [32*LANE_COUNT-1:0] s_tdata,
    input  logic                     s_tlast,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [32*LANE_COUNT-1:0] m_tdata,
    input  logic [LANE_COUNT:0]      m_tuser,
    input  logic                     m_tlast,
    output int                       errors,
    output int                       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] lane [LANE_COUNT];
        logic [3:0]  wr;
        logic        bad;
        logic        run_end;
    } unpacked_t;

    localparam logic [31:0] F32_32768 = 32'h4700_0000;
    localparam logic [31:0] F32_255   = 32'h437F_0000;

    logic [2:0]  fmt_q;
    logic [3:0]  mask_q;
    logic [31:0] scale_q;
    logic [31:0] fac_s16;
    logic [31:0] fac_u8;
    unpacked_t   expected_q [$];
    int          n_out;

    // round num * 2^e (plus sticky) to float32, nearest even, with subnormals
    function automatic logic [31:0] f32_round(input logic sgn, input logic [79:0] num,
                                              input int e, input logic stk);
        int          p;
        int          lsbw;
        int          sh;
        int          ef;
        logic [79:0] q;
        logic        g;
        logic        rest;
        p = -1;
        for (int i = 0; i < 80; i++) begin
            if (num[i]) p = i;
        end
        if (p < 0) return {sgn, 31'd0};
        lsbw = p + e - 23;
        if (lsbw < -149) lsbw = -149;
        sh = lsbw - e;
        if (sh <= 0) begin
            q    = num << (-sh);
            g    = 1'b0;
            rest = stk;
        end else begin
            q    = num >> sh;
            g    = num[sh-1];
            rest = stk | (|(num & ((80'd1 << (sh - 1)) - 80'd1)));
        end
        if (g && (rest || q[0])) q = q + 80'd1;
        if (q[24]) begin
            q    = q >> 1;
            lsbw = lsbw + 1;
        end
        if (!q[23]) return {sgn, 8'd0, q[22:0]};
        ef = lsbw + 150;
        if (ef >= 255) return {sgn, 8'hFF, 23'd0};
        return {sgn, ef[7:0], q[22:0]};
    endfunction

    function automatic logic [23:0] f32_mant(input logic [31:0] f);
        return (f[30:23] == 8'd0) ? {1'b0, f[22:0]} : {1'b1, f[22:0]};
    endfunction

    function automatic int f32_exp(input logic [31:0] f);
        return (f[30:23] == 8'd0) ? -149 : int'(f[30:23]) - 150;
    endfunction

    // a / d for a positive finite normal divisor d
    function automatic logic [31:0] f32_div(input logic [31:0] a, input logic [31:0] d);
        logic [79:0] num;
        logic [79:0] den;
        if (a[30:23] == 8'hFF) begin
            return (a[22:0] != 0) ? (a | FLT_QUIET_BIT) : {a[31], 8'hFF, 23'd0};
        end
        if (a[30:0] == 31'd0) return {a[31], 31'd0};
        den = 80'(f32_mant(d));
        num = (80'(f32_mant(a)) << 40) / den;
        return f32_round(a[31], num, f32_exp(a) - 40 - f32_exp(d),
                         ((80'(f32_mant(a)) << 40) % den) != 0);
    endfunction

    // float(v) * f for a small integer v
    function automatic logic [31:0] f32_mul_int(input int v, input logic [31:0] f);
        logic        sgn;
        logic [79:0] mag;
        sgn = (v < 0) ^ f[31];
        mag = 80'((v < 0) ? -v : v);
        if (f[30:23] == 8'hFF) begin
            if (f[22:0] != 0) return f | FLT_QUIET_BIT;
            return (mag == 0) ? FLT_DEFAULT_NAN : {sgn, 8'hFF, 23'd0};
        end
        if (mag == 0 || f[30:0] == 31'd0) return {sgn, 31'd0};
        return f32_round(sgn, mag * 80'(f32_mant(f)), f32_exp(f), 1'b0);
    endfunction

    function automatic unpacked_t unpack_vector(input logic [32*LANE_COUNT-1:0] src,
                                                input logic last);
        unpacked_t   r;
        logic [31:0] x;
        logic [31:0] v;
        logic [3:0]  en;
        en = mask_q;
        for (int k = 0; k < LANE_COUNT; k++) begin
            x = src[32*k +: 32];
            case (fmt_q)
                FMT_F32V4, FMT_F32V2: v = x;
                FMT_S16V4: v = f32_mul_int(int'($signed(x[15:0])), fac_s16);
                FMT_U8V4:  v = f32_mul_int(int'(x[7:0]), fac_u8);
                default:   v = 32'd0;
            endcase
            r.lane[k] = v;
        end
        r.bad = 1'b0;
        if (fmt_q == FMT_F32V2) begin
            en = en & 4'h3;
        end else if (fmt_q > FMT_F32V2) begin
            en    = 4'h0;
            r.bad = 1'b1;
        end
        for (int k = 0; k < LANE_COUNT; k++) begin
            if (!en[k]) r.lane[k] = 32'd0;
        end
        r.wr      = en;
        r.run_end = last;
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch result %0d %s: got %h expected %h", n_out, what, got, want);
        errors = errors + 1;
    endtask

    assign pending = expected_q.size();

    // sample at the edge: values seen here are the pre-edge ones
    always @(posedge aclk) begin
        unpacked_t want;
        if (!aresetn) begin
            fmt_q   <= FORMAT_RESET;
            mask_q  <= MASK_RESET;
            scale_q <= SCALE_RESET;
            fac_s16 <= f32_div(SCALE_RESET, F32_32768);
            fac_u8  <= f32_div(SCALE_RESET, F32_255);
            expected_q.delete();
            n_out = 0;
            errors = 0;
        end else begin
            // config transfer
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FORMAT: begin
                        fmt_q   <= cfg_data[2:0];
                        fac_s16 <= f32_div(scale_q, F32_32768);
                        fac_u8  <= f32_div(scale_q, F32_255);
                    end
                    CFG_MASK: mask_q <= cfg_data[3:0];
                    CFG_SCALE: begin
                        scale_q <= cfg_data;
                        fac_s16 <= f32_div(cfg_data, F32_32768);
                        fac_u8  <= f32_div(cfg_data, F32_255);
                    end
                    default: ;
                endcase
            end
            // source transfer
            if (s_tvalid && s_tready) expected_q.push_back(unpack_vector(s_tdata, s_tlast));
            // result transfer
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected", {31'd0, m_tvalid}, 32'd0);
                end else begin
                    want = expected_q.pop_front();
                    for (int k = 0; k < LANE_COUNT; k++) begin
                        if (m_tdata[32*k +: 32] !== want.lane[k])
                            report($sformatf("dst_lane%0d", k), m_tdata[32*k +: 32],
                                   want.lane[k]);
                    end
                    if (m_tuser[3:0] !== want.wr)
                        report("lane_write", 32'(m_tuser[3:0]), 32'(want.wr));
                    if (m_tuser[4] !== want.bad)
                        report("bad_format", 32'(m_tuser[4]), 32'(want.bad));
                    if (m_tlast !== want.run_end)
                        report("run_end", 32'(m_tlast), 32'(want.run_end));
                end
                n_out = n_out + 1;
            end
        end
    end

endmodule

// File: test/vector_unpack_to_float4_core_tb.sv
// vector_unpack_to_float4_core_tb: drives config writes and source vectors with random
// gaps and back-pressure, gives the verdict; depends on vupf_pkg, the core and the checker
module vector_unpack_to_float4_core_tb import vupf_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] FMT_BAD_LO = 3'd4;
    localparam logic [2:0] FMT_BAD_HI = 3'd7;
    localparam logic [1:0] CFG_NONE   = 2'd3;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [1:0]               cfg_index;
    logic [31:0]              cfg_data;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [32*LANE_COUNT-1:0] s_tdata;   // src_lane0 .. src_lane3
    logic                     s_tlast;   // last_vector
    logic                     m_tvalid;
    logic                     m_tready;
    logic [32*LANE_COUNT-1:0] m_tdata;   // dst_lane0 .. dst_lane3
    logic [LANE_COUNT:0]      m_tuser;   // lane_write[3:0], bad_format[4]
    logic                     m_tlast;   // run_end
    int                       errors;
    int                       pending;
    logic                     no_idle;
    logic [2:0]               cur_fmt;
    int                       stall_left;

    vector_unpack_to_float4_core dut (.*);

    vector_unpack_to_float4_core_chk chk (.*);

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (no_idle || $urandom_range(0, 99) < 70) begin
            m_tready <= 1'b1;
        end else begin
            m_tready   <= 1'b0;
            stall_left <= pick_gap();
        end
    end

    task automatic send_vec(input logic [32*LANE_COUNT-1:0] data, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // wait for the block to drain, then write one register
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_FORMAT) cur_fmt = value[2:0];
    endtask

    function automatic logic [31:0] pick_float();
        logic [31:0] specials [10];
        specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0000, 32'h7F80_0001, 32'h0000_0001, 32'h7F7F_FFFF,
                     32'hFFFF_FFFF, 32'h3F80_0000};
        if ($urandom_range(0, 9) < 4) return specials[$urandom_range(0, 9)];
        return $urandom;
    endfunction

    function automatic logic [31:0] pick_lane();
        logic [15:0] ends [6];
        ends = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h00FF, 16'h0080};
        if (cur_fmt == FMT_S16V4 || cur_fmt == FMT_U8V4) begin
            if ($urandom_range(0, 9) < 3)
                return {16'($urandom_range(0, 65535)), ends[$urandom_range(0, 5)]};
            return $urandom;
        end
        return pick_float();
    endfunction

    function automatic logic [31:0] pick_scale();
        logic [31:0] scales [10];
        scales = '{32'h3F80_0000, 32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                   32'hFF80_0000, 32'h7FC0_0001, 32'h0000_0001, 32'h7F7F_FFFF,
                   32'hFFFF_FFFF, 32'h0080_0000};
        if ($urandom_range(0, 1) == 0) return scales[$urandom_range(0, 9)];
        return $urandom;
    endfunction

    initial begin
        logic [32*LANE_COUNT-1:0] v;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_FORMAT;
        cfg_data  <= 32'd0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        no_idle   = 1'b0;
        cur_fmt   = FORMAT_RESET;
        aresetn   <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, float specials
        send_vec({32'h7F80_0001, 32'hFF80_0000, 32'h8000_0000, 32'h0000_0000}, 1'b0);
        send_vec({32'hFFFF_FFFF, 32'h0000_0001, 32'h7F7F_FFFF, 32'h7FC0_0000}, 1'b1);
        // signed 16 extremes, high bits set
        write_reg(CFG_FORMAT, {29'h1FFF_FFFF, FMT_S16V4});
        send_vec({32'hFFFF_0000, 32'hABCD_FFFF, 32'h0000_8000, 32'h1234_7FFF}, 1'b0);
        send_vec({32'h0000_0001, 32'hFFFF_FFFE, 32'hFFFF_8001, 32'h0000_0000}, 1'b1);
        // unsigned 8 extremes
        write_reg(CFG_FORMAT, {29'd0, FMT_U8V4});
        send_vec({32'hFFFF_FF00, 32'h0000_00FF, 32'h0000_0080, 32'hFFFF_FF7F}, 1'b1);
        // overflowing, non-finite and subnormal scales
        write_reg(CFG_SCALE, 32'h7F7F_FFFF);
        send_vec({32'h0000_00FF, 32'h0000_0001, 32'h0000_0000, 32'h0000_0080}, 1'b0);
        write_reg(CFG_FORMAT, {29'd0, FMT_S16V4});
        send_vec({32'h0000_7FFF, 32'h0000_8000, 32'h0000_0000, 32'h0000_0001}, 1'b0);
        write_reg(CFG_SCALE, 32'hFF80_0000);
        send_vec({32'h0000_7FFF, 32'h0000_8000, 32'h0000_0000, 32'h0000_0001}, 1'b1);
        write_reg(CFG_SCALE, 32'h0000_0001);
        send_vec({32'h0000_7FFF, 32'h0000_8000, 32'h0000_0000, 32'h0000_4000}, 1'b0);
        // two-element format with a full mask
        write_reg(CFG_FORMAT, {29'd0, FMT_F32V2});
        send_vec({32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h4444_4444}, 1'b1);
        // disabled lanes, then no lanes
        write_reg(CFG_FORMAT, {29'd0, FMT_F32V4});
        write_reg(CFG_MASK, 32'hFFFF_FFF5);
        send_vec({32'h4444_4444, 32'h3333_3333, 32'h2222_2222, 32'h1111_1111}, 1'b0);
        write_reg(CFG_MASK, 32'd0);
        send_vec({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1);
        // invalid formats and an out-of-range index
        write_reg(CFG_MASK, 32'd15);
        write_reg(CFG_FORMAT, {29'd0, FMT_BAD_LO});
        send_vec({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1);
        write_reg(CFG_NONE, 32'hFFFF_FFFF);
        write_reg(CFG_FORMAT, {29'd0, FMT_BAD_HI});
        send_vec({32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0);

        // random phases: new settings, then a run of vectors
        for (int ph = 0; ph < 24; ph++) begin
            no_idle = (ph % 6 == 5);
            if ($urandom_range(0, 2) != 0) write_reg(CFG_SCALE, pick_scale());
            if ($urandom_range(0, 2) != 0) write_reg(CFG_MASK, $urandom);
            write_reg(CFG_FORMAT, ($urandom_range(0, 9) < 8) ?
                      {29'($urandom_range(0, 1 << 28)), 1'b0, 2'($urandom_range(0, 3))}
                      : $urandom);
            for (int n = 0; n < 25; n++) begin
                for (int k = 0; k < LANE_COUNT; k++) v[32*k +: 32] = pick_lane();
                send_vec(v, (n == 24) || ($urandom_range(0, 7) == 0));
            end
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;

        // drain, then allow for trailing results
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("vector_unpack_to_float4_core regression: pass");
        end else begin
            $display("vector_unpack_to_float4_core regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("vector_unpack_to_float4_core regression: fail");
        $finish;
    end

endmodule

// File: sim.f
hdl/vupf_pkg.sv
hdl/vupf_front.sv
hdl/vupf_queue.sv
hdl/vupf_fdiv.sv
hdl/vupf_back.sv
hdl/vector_unpack_to_float4_core.sv
test/vector_unpack_to_float4_core_chk.sv
test/vector_unpack_to_float4_core_tb.sv
